@@ hw/rtl/gha_pkg.sv @@
// Shared types and constants of the generation handle allocator.
// Used by every module under hw/rtl; depends on nothing else.
package gha_pkg;

	// table geometry
	localparam int SLOTS           = 256;
	localparam int SLOT_W          = $clog2(SLOTS);
	localparam int SLOT_FIELD_BITS = 16;
	localparam int GEN_BITS        = 16;
	localparam int HANDLE_W        = 32;
	localparam int HGEN_W          = HANDLE_W - SLOT_FIELD_BITS;
	localparam int SIZE_W          = 16;
	localparam int STATUS_W        = 2;
	localparam int OP_W            = 2;

	// free-slot search is split into groups of rows
	localparam int GRP_SLOTS = 16;
	localparam int GRP_W     = $clog2(GRP_SLOTS);
	localparam int GRPS      = SLOTS / GRP_SLOTS;
	localparam int GSEL_W    = $clog2(GRPS);

	localparam logic [SIZE_W-1:0] SIZE_LIMIT_RST = SIZE_W'(1024);

	typedef enum logic [OP_W-1:0] {
		OP_OPEN     = 2'd0,
		OP_VALIDATE = 2'd1,
		OP_CLOSE    = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// free-slot search result
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
	} find_t;

endpackage

@@ hw/rtl/gha_gen_mem.sv @@
// Generation memory: one entry per slot, with a registered synchronous read.
// Entries never written read as zero through a row of written flags.
// Depends on gha_pkg.
module gha_gen_mem (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                rd_en,
	input  logic [gha_pkg::SLOT_W-1:0]          rd_addr,
	output logic [gha_pkg::GEN_BITS-1:0]        rd_data,
	input  logic                                wr_en,
	input  logic [gha_pkg::SLOT_W-1:0]          wr_addr,
	input  logic [gha_pkg::GEN_BITS-1:0]        wr_data
);

	logic [gha_pkg::GEN_BITS-1:0] mem [gha_pkg::SLOTS];
	logic [gha_pkg::SLOTS-1:0]    written_q;
	logic [gha_pkg::GEN_BITS-1:0] rd_raw_q;
	logic                         rd_vld_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q <= mem[rd_addr];
		end
	end

	// track which entries hold a written generation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= written_q[rd_addr];
			end
		end
	end

	// unwritten entries read as the reset generation
	assign rd_data = rd_vld_q ? rd_raw_q : '0;

endmodule

@@ hw/rtl/gha_free_find.sv @@
// Lowest-free-slot search over the occupancy bitmap, slot 0 excluded.
// Two-level priority encode: first free group, then first free slot in it.
// Depends on gha_pkg.
module gha_free_find (
	input  logic [gha_pkg::SLOTS-1:0] occ,
	output gha_pkg::find_t            find
);

	logic [gha_pkg::SLOTS-1:0]     avail;
	logic [gha_pkg::GRPS-1:0]      grp_any;
	logic [gha_pkg::GSEL_W-1:0]    grp_sel;
	logic [gha_pkg::GRP_SLOTS-1:0] row;
	logic [gha_pkg::GRP_W-1:0]     bit_sel;

	// slot 0 is reserved and never handed out
	always_comb begin
		avail    = ~occ;
		avail[0] = 1'b0;
		for (int g = 0; g < gha_pkg::GRPS; g++) begin
			grp_any[g] = |avail[g*gha_pkg::GRP_SLOTS +: gha_pkg::GRP_SLOTS];
		end
	end

	// pick the lowest group with a free slot
	always_comb begin
		grp_sel = '0;
		for (int g = gha_pkg::GRPS - 1; g >= 0; g--) begin
			if (grp_any[g]) begin
				grp_sel = gha_pkg::GSEL_W'(g);
			end
		end
	end

	// pick the lowest free slot inside that group
	always_comb begin
		row     = avail[grp_sel*gha_pkg::GRP_SLOTS +: gha_pkg::GRP_SLOTS];
		bit_sel = '0;
		for (int b = gha_pkg::GRP_SLOTS - 1; b >= 0; b--) begin
			if (row[b]) begin
				bit_sel = gha_pkg::GRP_W'(b);
			end
		end
	end

	assign find.found = |grp_any;
	assign find.slot  = {grp_sel, bit_sel};

endmodule

@@ hw/rtl/generation_handle_allocator.sv @@
// Generational handle table: open, validate and close requests on 256 slots.
// The request and the generation memory read are registered at the accepting
// edge, then the result and done are registered along with the write-back; busy
// for one cycle, and no new request is taken until that write-back is done.
// Reset: all slots free, generations zero, size limit 1024; no clearing pass.
// The receiver cannot stall: done pulses for one cycle per request.
module generation_handle_allocator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [gha_pkg::OP_W-1:0]         operation,
	input  logic [gha_pkg::HANDLE_W-1:0]     handle,
	input  logic [gha_pkg::SIZE_W-1:0]       requested_size,
	input  logic                             cfg_we,
	input  logic [gha_pkg::SIZE_W-1:0]       cfg_wdata,
	output logic                             done,
	output logic [gha_pkg::STATUS_W-1:0]     status,
	output logic [gha_pkg::HANDLE_W-1:0]     new_handle,
	output logic [7:0]                       slot_index
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t                          state_q;
	logic [gha_pkg::SIZE_W-1:0]      size_limit_q;
	logic [gha_pkg::SLOTS-1:0]       occ_q;
	gha_pkg::find_t                  find;
	logic                            accept;
	logic [gha_pkg::SLOT_W-1:0]      rd_addr;

	// request registers held for the execute cycle
	gha_pkg::op_t                    op_s1;
	logic [gha_pkg::SLOT_W-1:0]      slot_s1;
	logic                            slot_ok_s1;
	logic                            size_ok_s1;
	logic [gha_pkg::HGEN_W-1:0]      hgen_s1;

	logic [gha_pkg::GEN_BITS-1:0]    gen_rd;
	logic [gha_pkg::GEN_BITS-1:0]    gen_inc;
	logic                            live;
	logic                            gen_wr;
	logic                            occ_set;
	logic                            occ_clr;
	gha_pkg::status_t                status_d;
	logic [gha_pkg::HANDLE_W-1:0]    handle_d;
	logic [7:0]                      slot_d;

	gha_free_find u_find (
		.occ  (occ_q),
		.find (find)
	);

	gha_gen_mem u_gen (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (gen_rd),
		.wr_en   (gen_wr),
		.wr_addr (slot_s1),
		.wr_data (gen_inc)
	);

	assign busy   = (state_q == S_EXEC);
	assign accept = start && (state_q == S_IDLE);

	// address the free slot on open, the handle's slot otherwise
	assign rd_addr = (gha_pkg::op_t'(operation) == gha_pkg::OP_OPEN)
		? find.slot : handle[gha_pkg::SLOT_W-1:0];

	// latch the request at the accepting edge
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= gha_pkg::op_t'(operation);
			hgen_s1 <= handle[gha_pkg::HANDLE_W-1:gha_pkg::SLOT_FIELD_BITS];
			slot_s1 <= rd_addr;
			size_ok_s1 <= (requested_size != '0) && (requested_size <= size_limit_q);
			if (gha_pkg::op_t'(operation) == gha_pkg::OP_OPEN) begin
				slot_ok_s1 <= find.found;
			end else begin
				slot_ok_s1 <=
					(handle[gha_pkg::SLOT_FIELD_BITS-1:gha_pkg::SLOT_W] == '0) &&
					(handle[gha_pkg::SLOT_W-1:0] != '0);
			end
		end
	end

	// resolve the request against the read generation
	always_comb begin
		gen_inc  = gen_rd + 1'b1;
		live     = slot_ok_s1 && occ_q[slot_s1] && (gen_rd == hgen_s1);
		gen_wr   = 1'b0;
		occ_set  = 1'b0;
		occ_clr  = 1'b0;
		status_d = gha_pkg::ST_INVALID;
		handle_d = '0;
		slot_d   = '0;
		case (op_s1)
			gha_pkg::OP_OPEN: begin
				if (size_ok_s1) begin
					if (slot_ok_s1) begin
						status_d = gha_pkg::ST_OK;
						handle_d = gha_pkg::HANDLE_W'({gen_inc,
							gha_pkg::SLOT_FIELD_BITS'(slot_s1)});
						slot_d   = 8'(slot_s1);
						gen_wr   = busy;
						occ_set  = busy;
					end else begin
						status_d = gha_pkg::ST_FULL;
					end
				end
			end
			gha_pkg::OP_VALIDATE, gha_pkg::OP_CLOSE: begin
				if (live) begin
					status_d = gha_pkg::ST_OK;
					slot_d   = 8'(slot_s1);
					occ_clr  = busy && (op_s1 == gha_pkg::OP_CLOSE);
				end
			end
			default: begin
				status_d = gha_pkg::ST_INVALID;
			end
		endcase
	end

	// advance the sequencer, hold config, update occupancy and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			size_limit_q <= gha_pkg::SIZE_LIMIT_RST;
			occ_q        <= '0;
			done         <= 1'b0;
		end else begin
			if (cfg_we) begin
				size_limit_q <= cfg_wdata;
			end
			if (occ_set) begin
				occ_q[slot_s1] <= 1'b1;
			end else if (occ_clr) begin
				occ_q[slot_s1] <= 1'b0;
			end
			done <= busy;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result beat registers
	always_ff @(posedge clk) begin
		if (busy) begin
			status     <= status_d;
			new_handle <= handle_d;
			slot_index <= slot_d;
		end
	end

endmodule

@@ hw/rtl/gha_checker.sv @@
// Port-level checks for generation_handle_allocator, attached by bind.
// Depends on gha_pkg for status codes.
module gha_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic                             busy,
	input logic                             done,
	input logic [gha_pkg::STATUS_W-1:0]     status,
	input logic [gha_pkg::HANDLE_W-1:0]     new_handle,
	input logic [7:0]                       slot_index
);

	// an accepted request holds the block busy for the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted request");

	// every accepted request yields a result beat
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done)
		else $error("result beat missing after request");

	// no result beat without an earlier accepted request
	a_done_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result beat without request");

	// failed requests carry no handle and no slot
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != gha_pkg::ST_OK) |-> (new_handle == '0) && (slot_index == '0))
		else $error("failed request reports handle or slot");

	// an issued handle names a nonzero slot equal to the reported one
	a_handle_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done && (new_handle != '0) |->
			(new_handle[15:0] == {8'd0, slot_index}) && (slot_index != '0))
		else $error("issued handle does not match slot");

endmodule

bind generation_handle_allocator gha_checker u_gha_checker (.*);
